### hdl/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg: shared types and constants of the radio pulse sender
// Holds the phase codes, the queue entry and the register set types.
// ----------------------------------------------------------------------------
package prs_pkg;

   localparam int unsigned WORD_W    = 16;
   localparam int unsigned SAMPLE_W  = 24;
   localparam int unsigned CSR_W     = 16;
   localparam int unsigned REPEAT_W  = 4;
   localparam int unsigned INDEX_W   = 2;
   localparam int unsigned BIT_IDX_W = 4;
   localparam int unsigned RSP_W     = 8;

   localparam logic [WORD_W-1:0] PREAMBLE = 16'hF000;

   localparam logic [CSR_W-1:0]    PRE_BIT_DELAY_RST  = 16'd10;
   localparam logic [CSR_W-1:0]    BIT_DELAY_RST      = 16'd84;
   localparam logic [CSR_W-1:0]    PACKET_DELAY_RST   = 16'd1000;
   localparam logic [REPEAT_W-1:0] PACKET_REPEATS_RST = 4'd3;

   localparam logic [INDEX_W-1:0] REG_PRE_BIT_DELAY  = 2'd0;
   localparam logic [INDEX_W-1:0] REG_BIT_DELAY      = 2'd1;
   localparam logic [INDEX_W-1:0] REG_PACKET_DELAY   = 2'd2;
   localparam logic [INDEX_W-1:0] REG_PACKET_REPEATS = 2'd3;

   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_PRE  = 5'b00010,
      PH_HOLD = 5'b00100,
      PH_LOW  = 5'b01000,
      PH_GAP  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic              is_load;
      logic [WORD_W-1:0] word;
   } entry_type;

   typedef struct packed {
      logic [CSR_W-1:0]    pre_bit_delay;
      logic [CSR_W-1:0]    bit_delay;
      logic [CSR_W-1:0]    packet_delay;
      logic [REPEAT_W-1:0] packet_repeats;
   } csr_type;

endpackage

### hdl/prs_front.sv
// ----------------------------------------------------------------------------
// prs_front: request intake and classification
// Accepts request items, tells loads from ticks and builds the coded word.
// ----------------------------------------------------------------------------
module prs_front
   import prs_pkg::*;
(
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,
   input  logic                req_tuser,
   input  logic                q_full,
   output logic                q_push,
   output entry_type           q_entry
);

   function automatic logic [WORD_W-1:0] encode(input logic [SAMPLE_W-1:0] s);
      logic b11, b10, b9, b8, b7, b6, b5;
      logic p4, p3, p2, p1, p0;
      b11 = s[9];
      b10 = s[8];
      b9  = s[7];
      b8  = s[6];
      b7  = s[5];
      b6  = s[4];
      b5  = s[3];
      p4  = b11 ^ b10 ^ b9;
      p3  = b8 ^ b7 ^ b6;
      p2  = b11 ^ b10 ^ b8 ^ b7 ^ b5;
      p1  = b11 ^ b9 ^ b8 ^ b6 ^ b5;
      p0  = b11 ^ b10 ^ b9 ^ b8 ^ b7 ^ b6 ^ b5 ^ p4 ^ p3 ^ p2 ^ p1;
      return PREAMBLE | {4'b0000, s[9:3], p4, p3, p2, p1, p0};
   endfunction

   assign req_tready      = !q_full;
   assign q_push          = req_tvalid && !q_full;
   assign q_entry.is_load = req_tuser;
   assign q_entry.word    = encode(req_tdata);

endmodule

### hdl/prs_queue.sv
// ----------------------------------------------------------------------------
// prs_queue: two-entry queue between front and back
// Lets the intake and the timing engine stall independently.
// ----------------------------------------------------------------------------
module prs_queue
   import prs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output entry_type head
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hdl/prs_back.sv
// ----------------------------------------------------------------------------
// prs_back: pulse timing engine
// Steps the packet, bit and wait timing once per queued item and registers
// the response item.
// ----------------------------------------------------------------------------
module prs_back
   import prs_pkg::*;
#(
   parameter int unsigned DELAY_WIDTH = 16
)
(
   input  logic             clock,
   input  logic             reset,
   input  csr_type          csr,
   input  logic             q_not_empty,
   input  entry_type        q_head,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int unsigned CNT_W = (DELAY_WIDTH < CSR_W) ? DELAY_WIDTH : CSR_W;

   phase_type             phase_ff, phase_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [BIT_IDX_W-1:0]  bit_idx_ff, bit_idx_in;
   logic [REPEAT_W-1:0]   left_ff, left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [4:0]            rsp_data_ff;

   logic                  idle;
   logic [CSR_W-1:0]      sel_delay;
   logic [CNT_W:0]        eff_delay;
   logic [CNT_W:0]        cnt_plus;
   logic                  wait_end;
   logic [REPEAT_W-1:0]   left_dec;
   logic                  wv, wl, rej, done, busy;

   assign q_pop = q_not_empty && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      idle = !((phase_ff == PH_PRE) || (phase_ff == PH_HOLD) ||
               (phase_ff == PH_LOW) || (phase_ff == PH_GAP));
      unique case (phase_ff)
         PH_PRE:  sel_delay = csr.pre_bit_delay;
         PH_GAP:  sel_delay = csr.packet_delay;
         default: sel_delay = csr.bit_delay;
      endcase
      eff_delay = (sel_delay[CNT_W-1:0] == '0) ? (CNT_W+1)'(1)
                                                : {1'b0, sel_delay[CNT_W-1:0]};
      cnt_plus  = {1'b0, count_ff} + (CNT_W+1)'(1);
      wait_end  = (cnt_plus >= eff_delay);
      left_dec  = left_ff - REPEAT_W'(1);
   end

   always_comb begin
      phase_in   = phase_ff;
      word_in    = word_ff;
      count_in   = count_ff;
      bit_idx_in = bit_idx_ff;
      left_in    = left_ff;
      wv         = 1'b0;
      wl         = 1'b0;
      rej        = 1'b0;
      done       = 1'b0;
      if (q_head.is_load) begin
         if (idle) begin
            word_in    = q_head.word;
            phase_in   = PH_PRE;
            count_in   = '0;
            bit_idx_in = '1;
            left_in    = (csr.packet_repeats == '0) ? REPEAT_W'(1) : csr.packet_repeats;
         end else begin
            rej = 1'b1;
         end
      end else begin
         count_in = wait_end ? '0 : cnt_plus[CNT_W-1:0];
         unique case (phase_ff)
            PH_PRE: begin
               if (wait_end) begin
                  wv       = 1'b1;
                  wl       = word_ff[bit_idx_ff];
                  phase_in = PH_HOLD;
               end
            end
            PH_HOLD: begin
               if (wait_end) begin
                  wv       = 1'b1;
                  phase_in = PH_LOW;
               end
            end
            PH_LOW: begin
               if (wait_end) begin
                  if (bit_idx_ff == '0) begin
                     phase_in = PH_GAP;
                  end else begin
                     bit_idx_in = bit_idx_ff - BIT_IDX_W'(1);
                     phase_in   = PH_PRE;
                  end
               end
            end
            PH_GAP: begin
               if (wait_end) begin
                  left_in    = left_dec;
                  bit_idx_in = '1;
                  if (left_dec == '0) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_PRE;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
               count_in = count_ff;
            end
         endcase
      end
      busy         = (phase_in != PH_IDLE);
      rsp_valid_in = q_pop ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         word_ff      <= '0;
         count_ff     <= '0;
         bit_idx_ff   <= '1;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff   <= phase_in;
            word_ff    <= word_in;
            count_ff   <= count_in;
            bit_idx_ff <= bit_idx_in;
            left_ff    <= left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= {done, rej, busy, wl, wv};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

   a_done_from_gap: assert property (@(posedge clock) disable iff (reset)
      (q_pop && done) |-> (phase_ff == PH_GAP))
      else $error("transmission ended outside the packet gap");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[4]) |-> !rsp_data_ff[2])
      else $error("done item still reports busy");

   a_level_needs_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[0]) |-> !rsp_data_ff[1])
      else $error("line level set without a write");

   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[3]) |-> (rsp_data_ff[2] && !rsp_data_ff[0]))
      else $error("rejected load while not busy or with a write");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      !q_pop |=> $stable(phase_ff) && $stable(count_ff))
      else $error("timing state moved without an item");

endmodule

### hdl/parity_coded_radio_pulse_sender_core.sv
// ----------------------------------------------------------------------------
// parity_coded_radio_pulse_sender_core: parity-coded radio pulse sender
// Builds a parity-protected word from each load item and times its pulses
// onto the radio line, one tick item at a time.
//
//   Channel  Direction  Handshake                Payload
//   req_     in         req_tvalid/req_tready    tuser: req_type, tdata: sample
//   rsp_     out        rsp_tvalid/rsp_tready    tdata: write_valid .. done_res
//   csr_     in         csr_valid/csr_ready      csr_index, csr_data
//
// One item is accepted and one response produced per cycle while the response side
// is not stalled; the timing engine in the back part sets that rate.
// Each item passes through the queue and then the response register before its response appears.
// Reset restores the register defaults, empties the queue and idles the engine.
// A stalled response holds in its register; two queued items absorb the stall.
// ----------------------------------------------------------------------------
module parity_coded_radio_pulse_sender_core
   import prs_pkg::*;
#(
   parameter int unsigned DELAY_WIDTH = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,   // [23:0] sample
   input  logic                req_tuser,   // [0] req_type
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata,   // [0] write_valid, [1] write_level,
                                            // [2] busy_res, [3] load_rejected,
                                            // [4] done_res, [7:5] zero
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [INDEX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]    csr_data
);

   csr_type   csr_ff, csr_in;
   logic      q_full, q_push, q_pop, q_not_empty;
   entry_type q_entry, q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_PRE_BIT_DELAY:  csr_in.pre_bit_delay  = csr_data;
            REG_BIT_DELAY:      csr_in.bit_delay      = csr_data;
            REG_PACKET_DELAY:   csr_in.packet_delay   = csr_data;
            REG_PACKET_REPEATS: csr_in.packet_repeats = csr_data[REPEAT_W-1:0];
            default:            csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.pre_bit_delay  <= PRE_BIT_DELAY_RST;
         csr_ff.bit_delay      <= BIT_DELAY_RST;
         csr_ff.packet_delay   <= PACKET_DELAY_RST;
         csr_ff.packet_repeats <= PACKET_REPEATS_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   prs_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   prs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   prs_back #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_ff),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

### tb/tb_parity_coded_radio_pulse_sender_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_parity_coded_radio_pulse_sender_core: testbench of the radio pulse sender
// Drives load and tick items into the sender and predicts the radio line
// writes, busy flag, rejected loads and end of transmission for each accepted
// item. Every response is checked against the oldest prediction. Register
// settings run from the reset defaults through zero and full-scale values,
// with random idling on both channels and a long response hold-off.
// ----------------------------------------------------------------------------
module tb_parity_coded_radio_pulse_sender_core;
   import prs_pkg::*;

   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned DRAIN_CYCLES  = 4;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned DEFAULT_TICKS = 180;
   localparam int unsigned LONG_TICKS    = 120;

   typedef struct packed {
      logic done;
      logic rejected;
      logic busy;
      logic level;
      logic strobe;
   } line_event_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata;
   logic                req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_valid;
   logic                csr_ready;
   logic [INDEX_W-1:0]  csr_index;
   logic [CSR_W-1:0]    csr_data;

   // Predicted sender state and register copy.
   logic [CSR_W-1:0]     r_pre;
   logic [CSR_W-1:0]     r_bit;
   logic [CSR_W-1:0]     r_pkt;
   logic [REPEAT_W-1:0]  r_rep;
   logic [WORD_W-1:0]    m_word;
   phase_type            m_phase;
   int unsigned          m_wait;
   logic [BIT_IDX_W-1:0] m_bit;
   logic [REPEAT_W-1:0]  m_left;

   line_event_type pending_events[$];
   int             outstanding = 0;
   logic           model_idle = 1'b1;
   int             error_count = 0;
   int unsigned    cycle_count = 0;
   int             send_idle_pct = 0;
   int             stall_pct = 0;
   int             hold_asked = 0;
   int             hold_served = 0;

   always #5 clock = ~clock;

   parity_coded_radio_pulse_sender_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   function automatic int unsigned ticks_of(input logic [CSR_W-1:0] value);
      return (value == 0) ? 1 : 32'(value);
   endfunction

   // Advances the predicted sender by one accepted item.
   function automatic line_event_type predict_line_event(input logic is_load,
                                                         input logic [SAMPLE_W-1:0] smp);
      line_event_type ev;
      logic [WORD_W-1:0] w;
      int unsigned limit;
      ev = '0;
      if (is_load) begin
         if (m_phase == PH_IDLE) begin
            w = PREAMBLE | {4'h0, smp[9:3], 5'h00};
            w[4] = w[11] ^ w[10] ^ w[9];
            w[3] = w[8] ^ w[7] ^ w[6];
            w[2] = w[11] ^ w[10] ^ w[8] ^ w[7] ^ w[5];
            w[1] = w[11] ^ w[9] ^ w[8] ^ w[6] ^ w[5];
            w[0] = (^w[11:5]) ^ (^w[4:1]);
            m_word  = w;
            m_phase = PH_PRE;
            m_wait  = 0;
            m_bit   = 4'd15;
            m_left  = (r_rep == 0) ? 4'd1 : r_rep;
         end else begin
            ev.rejected = 1'b1;
         end
      end else if (m_phase != PH_IDLE) begin
         case (m_phase) inside
            PH_PRE:          limit = ticks_of(r_pre);
            PH_HOLD, PH_LOW: limit = ticks_of(r_bit);
            default:         limit = ticks_of(r_pkt);
         endcase
         m_wait++;
         if (m_wait >= limit) begin
            m_wait = 0;
            case (m_phase)
               PH_PRE: begin
                  ev.strobe = 1'b1;
                  ev.level  = m_word[m_bit];
                  m_phase   = PH_HOLD;
               end
               PH_HOLD: begin
                  ev.strobe = 1'b1;
                  m_phase   = PH_LOW;
               end
               PH_LOW: begin
                  if (m_bit == 0) begin
                     m_phase = PH_GAP;
                  end else begin
                     m_bit--;
                     m_phase = PH_PRE;
                  end
               end
               default: begin
                  m_left--;
                  m_bit = 4'd15;
                  if (m_left == 0) begin
                     m_phase = PH_IDLE;
                     ev.done = 1'b1;
                  end else begin
                     m_phase = PH_PRE;
                  end
               end
            endcase
         end
      end
      ev.busy = (m_phase != PH_IDLE);
      return ev;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 100) begin
         $display("%0t ns: %s", $time, msg);
      end
   endtask

   // Checks responses, records accepted items and register writes.
   always @(posedge clock) begin
      line_event_type want;
      line_event_type got;
      string names[5];
      names = '{"write_valid", "write_level", "busy_res", "load_rejected", "done_res"};
      if (reset) begin
         r_pre   = PRE_BIT_DELAY_RST;
         r_bit   = BIT_DELAY_RST;
         r_pkt   = PACKET_DELAY_RST;
         r_rep   = PACKET_REPEATS_RST;
         m_word  = '0;
         m_phase = PH_IDLE;
         m_wait  = 0;
         m_bit   = 4'd15;
         m_left  = '0;
         pending_events.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[4:0];
            if (pending_events.size() == 0) begin
               report_mismatch($sformatf("Response %h arrived with no item waiting.", rsp_tdata));
            end else begin
               want = pending_events.pop_front();
               for (int i = 0; i < 5; i++) begin
                  if (got[i] !== want[i]) begin
                     report_mismatch($sformatf("Field %s is %b, expected %b.",
                                               names[i], got[i], want[i]));
                  end
               end
               if (rsp_tdata[7:5] !== 3'b000) begin
                  report_mismatch($sformatf("Padding bits are %b, expected zero.",
                                            rsp_tdata[7:5]));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_events.push_back(predict_line_event(req_tuser, req_tdata));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PRE_BIT_DELAY:  r_pre = csr_data;
               REG_BIT_DELAY:      r_bit = csr_data;
               REG_PACKET_DELAY:   r_pkt = csr_data;
               REG_PACKET_REPEATS: r_rep = csr_data[REPEAT_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding <= pending_events.size();
      model_idle  <= (m_phase == PH_IDLE);
   end

   // Response side: random stalls, and a long hold-off whenever one is asked for.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            hold_served <= hold_served + 1;
            rsp_tready  <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_item(input logic is_load, input logic [SAMPLE_W-1:0] smp);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= is_load;
      req_tdata  <= smp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops offering items and waits until every predicted response has come.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_W-1:0] pre, input logic [CSR_W-1:0] bitd,
                             input logic [CSR_W-1:0] pkt, input logic [CSR_W-1:0] rep);
      logic [CSR_W-1:0]   vals[4];
      logic [INDEX_W-1:0] regs[4];
      vals = '{pre, bitd, pkt, rep};
      regs = '{REG_PRE_BIT_DELAY, REG_BIT_DELAY, REG_PACKET_DELAY, REG_PACKET_REPEATS};
      settle();
      csr_valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= regs[i];
         csr_data  <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // Loads one sample and ticks until the whole transmission has ended.
   task automatic send_transmission(input logic [SAMPLE_W-1:0] smp);
      int unsigned reps;
      int unsigned total;
      send_item(1'b1, smp);
      reps  = (r_rep == 0) ? 1 : 32'(r_rep);
      total = reps * (16 * (ticks_of(r_pre) + 2 * ticks_of(r_bit)) + ticks_of(r_pkt));
      for (int unsigned n = 0; n < total; n++) begin
         send_item(1'b0, SAMPLE_W'($urandom()));
      end
   endtask

   // Ticks until the predicted sender has gone idle.
   task automatic finish_transmission();
      while (!model_idle) begin
         send_item(1'b0, SAMPLE_W'($urandom()));
      end
   endtask

   task automatic test_default_registers();
      send_item(1'b1, 24'h0002A8);
      for (int unsigned n = 0; n < DEFAULT_TICKS; n++) begin
         send_item(1'b0, SAMPLE_W'($urandom()));
      end
      settle();
   endtask

   task automatic test_sample_extremes();
      logic [SAMPLE_W-1:0] samples[5];
      samples = '{24'h000000, 24'hFFFFFF, 24'h000008, 24'h000200, 24'hFFFC07};
      set_config(16'd1, 16'd1, 16'd1, 16'd1);
      finish_transmission();
      send_item(1'b0, 24'hFFFFFF);
      for (int i = 0; i < 5; i++) begin
         send_item(1'b1, samples[i]);
         send_item(1'b1, ~samples[i]);
         send_transmission(samples[i]);
         send_item(1'b0, 24'h000000);
      end
      settle();
   endtask

   task automatic test_zero_registers();
      set_config(16'd0, 16'd0, 16'd0, 16'd0);
      send_transmission(24'hFFFFFF);
      send_item(1'b1, 24'h5A5A5A);
      send_transmission(24'hA5A5A5);
      settle();
   endtask

   task automatic test_full_repeats();
      set_config(16'd0, 16'd0, 16'd0, 16'hFFFF);
      send_transmission(SAMPLE_W'($urandom()));
      settle();
   endtask

   task automatic test_long_waits();
      set_config(16'd100, 16'hFFFF, 16'hFFFF, 16'hFFF1);
      send_item(1'b1, SAMPLE_W'($urandom()));
      for (int unsigned n = 0; n < LONG_TICKS; n++) begin
         send_item(1'b0, SAMPLE_W'($urandom()));
      end
      settle();
   endtask

   task automatic test_output_backpressure();
      set_config(16'd0, 16'd1, 16'd2, 16'd2);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_asked    = hold_asked + 1;
      for (int i = 0; i < 80; i++) begin
         send_item((i % 40) == 0 || $urandom_range(99) < 3, SAMPLE_W'($urandom()));
      end
      settle();
      for (int i = 0; i < 60; i++) begin
         send_item(model_idle && $urandom_range(99) < 50, SAMPLE_W'($urandom()));
      end
      settle();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall, input int count);
      logic is_load;
      set_config(CSR_W'($urandom_range(0, 3)), CSR_W'($urandom_range(0, 2)),
                 CSR_W'($urandom_range(0, 8)),
                 {12'($urandom_range(0, 4095)), 4'($urandom_range(0, 3))});
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      for (int i = 0; i < count; i++) begin
         if (model_idle) begin
            is_load = ($urandom_range(99) < 60);
         end else begin
            is_load = ($urandom_range(99) < 3);
         end
         send_item(is_load, SAMPLE_W'($urandom()));
      end
      settle();
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = REG_PRE_BIT_DELAY;
      csr_data   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_default_registers();
      test_sample_extremes();
      test_zero_registers();
      test_full_repeats();
      test_long_waits();
      test_output_backpressure();
      test_random_traffic(0, 0, 50);
      test_random_traffic(51, 0, 50);
      test_random_traffic(0, 51, 50);
      test_random_traffic(37, 37, 50);
      settle();
      if (outstanding != 0) begin
         report_mismatch($sformatf("%0d responses never arrived.", outstanding));
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
